@@ hw/rtl/control_point_curve_interpolator_assert.svh @@
// Assertion macros used by the interpolator top level.
`ifndef CONTROL_POINT_CURVE_INTERPOLATOR_ASSERT_SVH
`define CONTROL_POINT_CURVE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CPCI_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CPCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CPCI_ASSERT(lbl, cond, msg)
`define CPCI_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/cpci_pkg.sv @@
// Types, codes and constants of the control point curve interpolator.
`default_nettype none
package cpci_pkg;
  localparam int MAX_POINTS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int DATA_W  = 24;
  localparam int AL_BITS = 16;
  localparam int DIV_NW  = DATA_W + AL_BITS;
  localparam int CFG_W   = 7;

  localparam logic [4:0] POINT_COUNT_RST  = 5'd0;
  localparam logic [6:0] SAMPLE_COUNT_RST = 7'd10;
  localparam logic       INVERT_RST       = 1'b1;
  localparam logic       SQUARE_RST       = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_SWEEP = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_POINT_COUNT  = 2'd0,
    CFG_SAMPLE_COUNT = 2'd1,
    CFG_INVERT       = 2'd2,
    CFG_SQUARE       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [3:0]               point_index;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic                     last_flag;
    logic                     error_flag;
  } out_item_t;

  typedef struct packed {
    logic                     valid;
    logic                     collect;
    logic                     found;
    logic                     hit_zero;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] prev_x;
    logic signed [DATA_W-1:0] prev_y;
    logic signed [DATA_W-1:0] hit_x;
    logic signed [DATA_W-1:0] hit_y;
  } token_t;
endpackage
`default_nettype wire

@@ hw/rtl/cpci_if.sv @@
// Valid/ready channel interfaces for request and result items.
`default_nettype none
interface cpci_in_if;
  logic               valid;
  logic               ready;
  cpci_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpci_out_if;
  logic                valid;
  logic                ready;
  cpci_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cpci_cell.sv @@
// One control point cell: holds a point and updates the passing search token.
`default_nettype none
module cpci_cell #(
  parameter int K  = 0,
  parameter int CW = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             we,
  input  wire logic signed [cpci_pkg::DATA_W-1:0] wr_x,
  input  wire logic signed [cpci_pkg::DATA_W-1:0] wr_y,
  input  wire logic [CW-1:0]                    cnt,
  input  wire cpci_pkg::token_t                 tok_in,
  output cpci_pkg::token_t                      tok_out
);
  import cpci_pkg::*;

  logic signed [DATA_W-1:0] px;
  logic signed [DATA_W-1:0] py;
  token_t                   tok_next;
  logic                     active;

  assign active = (32'(cnt) > K);

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && active) begin
      if (tok_in.collect) begin
        if (K == 0) begin
          tok_next.hit_x = px;
        end
        tok_next.prev_x = px;
        tok_next.prev_y = py;
      end else if (!tok_in.found) begin
        if (tok_in.x < px) begin
          tok_next.found    = 1'b1;
          tok_next.hit_zero = (K == 0);
          tok_next.hit_x    = px;
          tok_next.hit_y    = py;
        end else begin
          tok_next.prev_x = px;
          tok_next.prev_y = py;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      px <= wr_x;
      py <= wr_y;
    end
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/cpci_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module cpci_div #(
  parameter int NW = 40,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rem
);
  localparam int SW = $clog2(NW + 1);

  logic [SW-1:0] steps;
  logic          busy;
  logic [DW-1:0] dreg;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial = {rem, quo[NW-1]};
    qbit  = (trial >= {1'b0, dreg});
    if (qbit) begin
      trial = trial - {1'b0, dreg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NW);
        quo   <= num;
        rem   <= '0;
        dreg  <= den;
      end else if (busy) begin
        quo   <= {quo[NW-2:0], qbit};
        rem   <= trial[DW-1:0];
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/control_point_curve_interpolator.sv @@
// Top level of the piecewise-linear control point curve interpolator.
// Control points sit in a row of MAX_POINTS cells; a search token walks the
// row one cell per cycle, and each evaluation first passes the token through
// the row. A point inside a segment then takes a serial division for alpha
// followed by square, multiply and add steps. A sweep spends one row pass and
// one division on setup and then a row pass per emitted point, plus the
// division and arithmetic for a point inside a segment. Loads and unknown
// requests give no result. One request is worked on at a time; a finished
// result waits in the output register.
`default_nettype none
`include "control_point_curve_interpolator_assert.svh"
module control_point_curve_interpolator #(
  parameter int MAX_POINTS  = cpci_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS   = cpci_pkg::FRAC_BITS_DEF,
  parameter int MAX_SAMPLES = cpci_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  cpci_in_if.sink                      in_ch,
  cpci_out_if.source                   out_ch,
  input  wire logic                    wr_en,
  input  wire logic [1:0]              wr_index,
  input  wire logic [cpci_pkg::CFG_W-1:0] wr_data
);
  import cpci_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic signed [DATA_W:0] HALF_U = (DATA_W + 1)'((1 << FRAC_BITS) >> 1);
  localparam logic [DATA_W:0] FMASK = ~((DATA_W + 1)'((1 << FRAC_BITS) - 1));
  localparam logic signed [DATA_W:0] TOP_W = (DATA_W + 1)'(24'h7FFFFF) & FMASK;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_STEP, S_DIV, S_SQ, S_MUL, S_Y, S_OUT
  } state_t;

  state_t state;

  logic [4:0] point_count;
  logic [6:0] sample_count;
  logic       invert_mode;
  logic       square_mode;

  logic [CW-1:0] cnt;
  logic [6:0]    n_clamp;

  token_t tok [MAX_POINTS+1];
  token_t tok_src;
  logic [MAX_POINTS-1:0] cell_we;
  logic in_acc;

  logic                     sweeping;
  logic                     errq;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] xf;
  logic signed [DATA_W-1:0] ya;
  logic signed [DATA_W-1:0] yb;
  logic signed [DATA_W-1:0] yv;
  logic [AL_BITS:0]         al;
  logic signed [42:0]       prod;
  logic [6:0]               n_reg;
  logic [6:0]               idx;
  logic [7:0]               dden;
  logic signed [26:0]       q_acc;
  logic signed [26:0]       q_step;
  logic [6:0]               r_acc;
  logic [6:0]               r_step;
  logic                     dneg;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DATA_W-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [DATA_W-1:0] div_rem;

  logic              o_valid;
  out_item_t         o_data;
  logic              o_free;

  logic signed [DATA_W:0] dx;
  logic [25:0]            dx2_mag;
  logic signed [DATA_W:0] seg_d;
  logic [7:0]             r_sum;
  logic signed [26:0]     q_adv;
  logic [6:0]             r_adv;
  logic signed [DATA_W:0] dy;
  logic [33:0]            sq;
  logic signed [42:0]     prod_r;

  function automatic logic signed [DATA_W-1:0] round_whole(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W:0] t;
    t = ((DATA_W + 1)'(v) + HALF_U) & FMASK;
    if (t > TOP_W) begin
      t = TOP_W;
    end
    return t[DATA_W-1:0];
  endfunction

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = o_valid;
  assign out_ch.data  = o_data;
  assign o_free       = !o_valid || out_ch.ready;

  always_comb begin
    cnt = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
    if (sample_count < 7'd2) begin
      n_clamp = 7'd2;
    end else if (32'(sample_count) > MAX_SAMPLES) begin
      n_clamp = 7'(MAX_SAMPLES);
    end else begin
      n_clamp = sample_count;
    end
    dx      = $signed({tok[MAX_POINTS].prev_x[DATA_W-1], tok[MAX_POINTS].prev_x})
            - $signed({tok[MAX_POINTS].hit_x[DATA_W-1], tok[MAX_POINTS].hit_x});
    dx2_mag = dx[DATA_W] ? 26'(-{dx, 1'b0}) : 26'({dx, 1'b0});
    seg_d   = $signed({tok[MAX_POINTS].hit_x[DATA_W-1], tok[MAX_POINTS].hit_x})
            - $signed({tok[MAX_POINTS].prev_x[DATA_W-1], tok[MAX_POINTS].prev_x});
    r_sum   = {1'b0, r_acc} + {1'b0, r_step};
    if (r_sum >= dden) begin
      r_adv = 7'(r_sum - dden);
      q_adv = q_acc + q_step + 27'sd1;
    end else begin
      r_adv = r_sum[6:0];
      q_adv = q_acc + q_step;
    end
    dy     = $signed({yb[DATA_W-1], yb}) - $signed({ya[DATA_W-1], ya});
    sq     = al * al + 34'(1 << (AL_BITS - 1));
    prod_r = dy * $signed({1'b0, al});
  end

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      cell_we[k] = in_acc && (in_ch.data.req_type == REQ_LOAD)
                && (32'(in_ch.data.point_index) == k);
    end
  end

  assign tok[0] = tok_src;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    cpci_cell #(.K(k), .CW(CW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .we     (cell_we[k]),
      .wr_x   (in_ch.data.point_x),
      .wr_y   (in_ch.data.point_y),
      .cnt    (cnt),
      .tok_in (tok[k]),
      .tok_out(tok[k+1])
    );
  end

  cpci_div #(.NW(DIV_NW), .DW(DATA_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= POINT_COUNT_RST;
      sample_count <= SAMPLE_COUNT_RST;
      invert_mode  <= INVERT_RST;
      square_mode  <= SQUARE_RST;
      tok_src      <= '0;
      div_start    <= 1'b0;
      o_valid      <= 1'b0;
      sweeping     <= 1'b0;
      errq         <= 1'b0;
    end else begin
      tok_src.valid <= 1'b0;
      div_start     <= 1'b0;
      if (o_valid && out_ch.ready) begin
        o_valid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          CFG_POINT_COUNT:  point_count  <= wr_data[4:0];
          CFG_SAMPLE_COUNT: sample_count <= wr_data[6:0];
          CFG_INVERT:       invert_mode  <= wr_data[0];
          CFG_SQUARE:       square_mode  <= wr_data[0];
          default:          ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.data.req_type == REQ_QUERY
                         || in_ch.data.req_type == REQ_SWEEP)) begin
            sweeping <= (in_ch.data.req_type == REQ_SWEEP);
            n_reg    <= n_clamp;
            dden     <= 8'({n_clamp - 7'd1, 1'b0});
            cur_x    <= in_ch.data.query_x;
            if (cnt == '0) begin
              errq  <= 1'b1;
              state <= S_OUT;
            end else begin
              errq    <= 1'b0;
              tok_src <= '{valid: 1'b1, collect: (in_ch.data.req_type == REQ_SWEEP),
                           found: 1'b0, hit_zero: 1'b0, x: in_ch.data.query_x,
                           prev_x: '0, prev_y: '0, hit_x: '0, hit_y: '0};
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok[MAX_POINTS].valid) begin
            if (tok[MAX_POINTS].collect) begin
              xf        <= tok[MAX_POINTS].hit_x;
              dneg      <= dx[DATA_W];
              div_num   <= DIV_NW'(dx2_mag);
              div_den   <= DATA_W'(dden);
              div_start <= 1'b1;
              state     <= S_STEP;
            end else if (!tok[MAX_POINTS].found) begin
              yv    <= tok[MAX_POINTS].prev_y;
              state <= S_OUT;
            end else if (tok[MAX_POINTS].hit_zero) begin
              yv    <= tok[MAX_POINTS].hit_y;
              state <= S_OUT;
            end else begin
              ya        <= tok[MAX_POINTS].prev_y;
              yb        <= tok[MAX_POINTS].hit_y;
              div_num   <= {24'($signed({cur_x[DATA_W-1], cur_x})
                                - $signed({tok[MAX_POINTS].prev_x[DATA_W-1],
                                           tok[MAX_POINTS].prev_x})),
                            AL_BITS'(0)};
              div_den   <= seg_d[DATA_W-1:0];
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_STEP: begin
          if (div_done) begin
            if (dneg && (div_rem != '0)) begin
              q_step <= -$signed({2'b0, div_quo[24:0]}) - 27'sd1;
              r_step <= 7'(dden - 8'(div_rem));
            end else if (dneg) begin
              q_step <= -$signed({2'b0, div_quo[24:0]});
              r_step <= '0;
            end else begin
              q_step <= $signed({2'b0, div_quo[24:0]});
              r_step <= div_rem[6:0];
            end
            q_acc   <= '0;
            r_acc   <= n_reg - 7'd1;
            idx     <= '0;
            cur_x   <= xf;
            tok_src <= '{valid: 1'b1, collect: 1'b0, found: 1'b0, hit_zero: 1'b0,
                         x: xf, prev_x: '0, prev_y: '0, hit_x: '0, hit_y: '0};
            state   <= S_SCAN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (invert_mode) begin
              ya <= yb;
              yb <= ya;
              al <= (AL_BITS + 1)'(1 << AL_BITS) - {1'b0, div_quo[AL_BITS-1:0]};
            end else begin
              al <= {1'b0, div_quo[AL_BITS-1:0]};
            end
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (square_mode) begin
            al <= sq[2*AL_BITS:AL_BITS];
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_r;
          state <= S_Y;
        end
        S_Y: begin
          yv    <= ya + DATA_W'((prod + 43'sd32768) >>> AL_BITS);
          state <= S_OUT;
        end
        S_OUT: begin
          if (o_free) begin
            o_valid <= 1'b1;
            if (errq) begin
              o_data <= '{out_x: '0, out_y: '0, last_flag: 1'b1, error_flag: 1'b1};
              state  <= S_IDLE;
            end else if (sweeping) begin
              o_data <= '{out_x: round_whole(cur_x), out_y: round_whole(yv),
                          last_flag: (idx == n_reg - 7'd1), error_flag: 1'b0};
              if (idx == n_reg - 7'd1) begin
                state <= S_IDLE;
              end else begin
                idx     <= idx + 7'd1;
                q_acc   <= q_adv;
                r_acc   <= r_adv;
                cur_x   <= xf + DATA_W'(q_adv);
                tok_src <= '{valid: 1'b1, collect: 1'b0, found: 1'b0, hit_zero: 1'b0,
                             x: xf + DATA_W'(q_adv), prev_x: '0, prev_y: '0,
                             hit_x: '0, hit_y: '0};
                state   <= S_SCAN;
              end
            end else begin
              o_data <= '{out_x: cur_x, out_y: yv, last_flag: 1'b1, error_flag: 1'b0};
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPCI_ASSERT_IMPL(a_tok_exit_scan, tok[MAX_POINTS].valid, state == S_SCAN, "token left row outside scan")
  `CPCI_ASSERT_IMPL(a_div_done_wait, div_done, state == S_DIV || state == S_STEP, "divider finished unexpectedly")
  `CPCI_ASSERT_IMPL(a_rem_bound, sweeping && state == S_OUT && !errq, {1'b0, r_acc} < dden, "sweep remainder out of range")
  `CPCI_ASSERT_IMPL(a_launch_idle, tok_src.valid, state == S_SCAN, "token launched outside scan")
endmodule
`default_nettype wire
